// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam int QUEUE_DEPTH = 4;

    // Item handed from the front to the back: a byte to place, and whether
    // the message closes after it.
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } item_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/core/sha256_front.sv =====
module sha256_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha256_pkg::item_t    in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output sha256_pkg::item_t    q_item
);

    localparam int AW = $clog2(sha256_pkg::QUEUE_DEPTH);

    sha256_pkg::item_t mem [sha256_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push, pop;

    // Idle items carry nothing and are dropped here.
    assign in_ready = (count_reg != (AW+1)'(sha256_pkg::QUEUE_DEPTH));
    assign push     = in_valid && in_ready && (in_item.present || in_item.last);
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_item   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/sha256_back.sv =====
module sha256_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sha256_pkg::item_t    q_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [31:0]          m_word,
    output logic [2:0]           m_index,
    output logic                 m_last
);

    typedef enum logic [4:0] {
        S_TAKE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t        state_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    bcnt_reg;
    logic [63:0]   len_reg;
    logic [5:0]    rnd_reg;
    logic          closing_reg;   // message has ended; padding still due
    logic          mark_reg;      // 0x80 marker already placed
    logic          lenblk_reg;    // current block carries the length field
    logic [2:0]    oidx_reg;

    logic [7:0]    pad_byte;
    logic          place;
    logic          mark_now;
    logic [7:0]    place_byte;
    logic [31:0]   s0, s1, wnext, bs0, bs1, ch, mj, t1, t2;
    logic [31:0]   wcur;

    assign q_ready = (state_reg == S_TAKE);

    // Padding byte for the current position once the message has closed.
    always_comb begin
        if (!mark_reg) begin
            pad_byte = sha256_pkg::PAD_BYTE;
        end else if (lenblk_reg && bcnt_reg[5:3] == 3'd7) begin
            pad_byte = len_reg[{~bcnt_reg[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    always_comb begin
        place      = 1'b0;
        mark_now   = 1'b0;
        place_byte = q_item.data;
        if (state_reg == S_TAKE && q_valid) begin
            place      = q_item.present || q_item.last;
            mark_now   = !q_item.present && q_item.last;
            place_byte = q_item.present ? q_item.data : sha256_pkg::PAD_BYTE;
        end else if (state_reg == S_PAD) begin
            place      = 1'b1;
            mark_now   = !mark_reg;
            place_byte = pad_byte;
        end
    end

    // Message schedule runs as a 16-word shift line: w_reg[0] is W[t].
    assign wcur  = w_reg[0];
    assign s0    = sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
                 ^ (w_reg[1] >> 3);
    assign s1    = sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
                 ^ (w_reg[14] >> 10);
    assign wnext = s1 + w_reg[9] + s0 + w_reg[0];
    assign bs1   = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
                 ^ sha256_pkg::rotr(v_reg[4], 25);
    assign ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1    = v_reg[7] + bs1 + ch + sha256_pkg::ROUND_K[rnd_reg] + wcur;
    assign bs0   = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
                 ^ sha256_pkg::rotr(v_reg[0], 22);
    assign mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2    = bs0 + mj;

    always_ff @(posedge aclk) begin
        if (place) begin
            unique case (bcnt_reg[1:0])
                2'd0: w_reg[bcnt_reg[5:2]] <= {place_byte, 24'h0};
                2'd1: w_reg[bcnt_reg[5:2]][23:16] <= place_byte;
                2'd2: w_reg[bcnt_reg[5:2]][15:8] <= place_byte;
                default: w_reg[bcnt_reg[5:2]][7:0] <= place_byte;
            endcase
        end else if (state_reg == S_ROUND) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnext;
        end
        if (place && bcnt_reg == 6'd63) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (state_reg == S_ROUND) begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_TAKE;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha256_pkg::INIT_HASH[i];
            bcnt_reg     <= '0;
            len_reg      <= '0;
            rnd_reg      <= '0;
            closing_reg  <= 1'b0;
            mark_reg     <= 1'b0;
            lenblk_reg   <= 1'b0;
            oidx_reg     <= '0;
        end else begin
            if (place) bcnt_reg <= bcnt_reg + 6'd1;
            if (mark_now) mark_reg <= 1'b1;
            unique case (state_reg)
                S_TAKE: begin
                    if (place) begin
                        if (q_item.present) len_reg <= len_reg + 64'd8;
                        if (q_item.last) closing_reg <= 1'b1;
                        // A marker that leaves room for the length keeps it in this block.
                        if (mark_now && bcnt_reg <= 6'd55) lenblk_reg <= 1'b1;
                        if (bcnt_reg == 6'd63) begin
                            state_reg <= S_ROUND;
                        end else if (q_item.last) begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (mark_now && bcnt_reg <= 6'd55) lenblk_reg <= 1'b1;
                    if (bcnt_reg == 6'd63) state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) state_reg <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (lenblk_reg) begin
                        state_reg <= S_OUT;
                        oidx_reg  <= '0;
                    end else if (mark_reg) begin
                        // The marker came too late; the length goes into a fresh block.
                        lenblk_reg <= 1'b1;
                        state_reg  <= S_PAD;
                    end else if (closing_reg) begin
                        state_reg <= S_PAD;
                    end else begin
                        state_reg <= S_TAKE;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7) begin
                            state_reg   <= S_TAKE;
                            closing_reg <= 1'b0;
                            mark_reg    <= 1'b0;
                            lenblk_reg  <= 1'b0;
                            len_reg     <= '0;
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha256_pkg::INIT_HASH[i];
                        end
                    end
                end
                default: begin
                    state_reg <= S_TAKE;
                end
            endcase
        end
    end

    assign m_valid = (state_reg == S_OUT);
    assign m_word  = h_reg[oidx_reg];
    assign m_index = oidx_reg;
    assign m_last  = (oidx_reg == 3'd7);

endmodule

// ===== rtl/core/sha256_message_digest_core.sv =====
// A transfer is written into the queue and read out of it by the block stage;
// bytes are taken one per cycle while that stage is in its intake state, and a full
// block then runs 64 rounds and the hash update. Intake stops during the rounds.
// The next block's bytes are taken only after the previous block's hash update.
// Closing a message pads one byte per cycle to the end of the block (plus a whole
// extra block when the marker lands past byte 55), then eight digest transfers.
// Reset (aresetn low, synchronous) empties the queue and restores the initial hash.
module sha256_message_digest_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // msg_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    sha256_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    assign in_item.data    = s_tdata;
    assign in_item.present = s_tuser;
    assign in_item.last    = s_tlast;

    sha256_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    sha256_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_word(m_tdata), .m_index(m_tuser), .m_last(m_tlast)
    );

endmodule
